FILE: rtl/ipf_pkg.sv
// shared types and constants of the destination-port filter
package ipf_pkg;

  // transaction opcodes on the input channel
  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_BLOCK   = 2'd1,
    OP_UNBLOCK = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // result kinds on the output channel
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_COUNT   = 1'b1;

  // header constants
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // counter indexes
  localparam int CNT_TOTAL   = 0;
  localparam int CNT_IPV4    = 1;
  localparam int CNT_IPV6    = 2;
  localparam int CNT_TCP     = 3;
  localparam int CNT_UDP     = 4;
  localparam int CNT_ICMP    = 5;
  localparam int CNT_OTHER   = 6;
  localparam int CNT_DROPPED = 7;
  localparam int CNT_PASSED  = 8;
  localparam int CNT_NUM     = 9;
  localparam int CNT_IDX_W   = 4;

  // bitmap memory shape: 16 ports per row
  localparam int PORT_W     = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int ROW_W      = 1 << BIT_IDX_W;
  localparam int ROW_ADDR_W = PORT_W - BIT_IDX_W;
  localparam int ROWS       = 1 << ROW_ADDR_W;

  localparam int OFF_W = 7;
  localparam int HL_W  = 6;

  typedef logic [CNT_NUM-1:0] cnt_bump_t;

  // frame classification at the last byte
  typedef struct packed {
    logic total;
    logic ipv4;
    logic ipv6;
    logic tcp;
    logic udp;
    logic icmp;
    logic other;
    logic check_port;
  } cls_t;

endpackage

FILE: rtl/ipf_parse.sv
// header parser: tracks offset, ethertype, ihl, protocol, destination port
module ipf_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_en,
  input  logic [7:0]             frame_byte,
  input  logic                   last,
  output logic [ipf_pkg::PORT_W-1:0] dest_port,
  output ipf_pkg::cls_t          cls
);
  import ipf_pkg::*;

  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [15:0]       eth_r, eth_nxt;
  logic [HL_W-1:0]   hl_r, hl_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  logic [OFF_W-1:0]  l4_off;
  logic [7:0]        len;
  logic [7:0]        l4_end;

  assign dest_port = port_r;
  assign l4_off    = 7'd14 + OFF_W'(hl_r);

  always_comb begin
    eth_nxt   = eth_r;
    hl_nxt    = hl_r;
    proto_nxt = proto_r;
    port_nxt  = port_r;
    if (off_r == 7'd12) eth_nxt = {frame_byte, eth_r[7:0]};
    if (off_r == 7'd13) eth_nxt = {eth_r[15:8], frame_byte};
    if (off_r == 7'd14) hl_nxt = {frame_byte[3:0], 2'b00};
    if (off_r == 7'd23) proto_nxt = frame_byte;
    if (off_r >= 7'd34 && off_r == l4_off + 7'd2) port_nxt = {frame_byte, port_r[7:0]};
    if (off_r >= 7'd34 && off_r == l4_off + 7'd3) port_nxt = {port_r[15:8], frame_byte};
  end

  // verdict class from the captured fields, current byte included
  assign len    = {1'b0, off_r} + 8'd1;
  assign l4_end = 8'd14 + 8'(hl_nxt);

  always_comb begin
    cls = '0;
    if (last) begin
      cls.total = 1'b1;
      if (len >= 8'd14) begin
        if (eth_nxt == ETYPE_IPV6) begin
          cls.ipv6 = 1'b1;
        end else if (eth_nxt == ETYPE_IPV4) begin
          cls.ipv4 = 1'b1;
          if (len >= 8'd34 && hl_nxt >= 6'd20 && len >= l4_end) begin
            case (proto_nxt)
              PROTO_TCP: begin
                cls.tcp        = 1'b1;
                cls.check_port = (len >= l4_end + 8'd20);
              end
              PROTO_UDP: begin
                cls.udp        = 1'b1;
                cls.check_port = (len >= l4_end + 8'd8);
              end
              PROTO_ICMP: cls.icmp = 1'b1;
              default: cls.other = 1'b1;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      eth_r   <= '0;
      hl_r    <= '0;
      proto_r <= '0;
      port_r  <= '0;
    end else if (byte_en) begin
      if (last) begin
        off_r   <= '0;
        eth_r   <= '0;
        hl_r    <= '0;
        proto_r <= '0;
        port_r  <= '0;
      end else begin
        if (off_r != {OFF_W{1'b1}}) off_r <= off_r + 7'd1;
        eth_r   <= eth_nxt;
        hl_r    <= hl_nxt;
        proto_r <= proto_nxt;
        port_r  <= port_nxt;
      end
    end
  end

endmodule

FILE: rtl/ipf_bitmap.sv
// blocked-port bitmap memory with clearing pass, read-modify-write and forwarding
module ipf_bitmap (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       busy,
  input  logic                       req_en,
  input  logic [ipf_pkg::PORT_W-1:0] req_port,
  input  logic                       upd_en,
  input  logic                       upd_set,
  output logic                       port_bit
);
  import ipf_pkg::*;

  logic [ROW_W-1:0]      mem [ROWS];
  logic [ROW_W-1:0]      rd_row_r;
  logic [ROW_ADDR_W-1:0] row_addr_r;
  logic [BIT_IDX_W-1:0]  bit_r;
  logic                  fwd_vld_r;
  logic [ROW_ADDR_W-1:0] fwd_addr_r;
  logic [ROW_W-1:0]      fwd_data_r;
  logic                  clr_busy_r;
  logic [ROW_ADDR_W-1:0] clr_addr_r;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_new;

  assign busy = clr_busy_r;

  // row as of now: last write-back may have landed after the read
  assign row_cur  = (fwd_vld_r && fwd_addr_r == row_addr_r) ? fwd_data_r : rd_row_r;
  assign port_bit = row_cur[bit_r];

  always_comb begin
    row_new        = row_cur;
    row_new[bit_r] = upd_set;
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (upd_en) begin
      mem[row_addr_r] <= row_new;
    end
    if (req_en) begin
      rd_row_r <= mem[req_port[PORT_W-1:BIT_IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (req_en) begin
      row_addr_r <= req_port[PORT_W-1:BIT_IDX_W];
      bit_r      <= req_port[BIT_IDX_W-1:0];
      fwd_addr_r <= row_addr_r;
      fwd_data_r <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (req_en) fwd_vld_r <= upd_en;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == {ROW_ADDR_W{1'b1}}) clr_busy_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/ipf_counters.sv
// class counters: one incrementer each, one read port by index
module ipf_counters #(
  parameter int CW = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipf_pkg::cnt_bump_t            bump,
  input  logic [ipf_pkg::CNT_IDX_W-1:0] rd_idx,
  output logic [CW-1:0]                 rd_val
);
  import ipf_pkg::*;

  logic [CW-1:0] cnt_r [CNT_NUM];

  always_comb begin
    rd_val = '0;
    if (rd_idx < CNT_IDX_W'(CNT_NUM)) rd_val = cnt_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CNT_NUM; i++) cnt_r[i] <= '0;
    end else begin
      for (int i = 0; i < CNT_NUM; i++) begin
        if (bump[i]) cnt_r[i] <= cnt_r[i] + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ipv4_port_filter_with_counters.sv
// top level of the destination-port packet filter with class counters
//
// input channel: one transaction per frame byte or command; in_tuser is the
// opcode (frame byte, block port, unblock port, read counter), in_tlast marks
// the last byte of a frame. frame bytes and commands may interleave freely.
// output channel: one transaction per last frame byte (verdict, out_tuser 0)
// and per counter read (out_tuser 1). block/unblock give no transaction.
// out_tvalid rises once the item has passed the bitmap row read (stage 1)
// and then the output register; throughput is one transaction per cycle
// when not stalled, since the bitmap memory reads one row and writes one row
// each cycle: block/unblock read a row on acceptance and write it back as
// they leave stage 1, with the pending write-back forwarded to a following
// read of the same row. after reset the bitmap (4096 rows of 16 ports) is
// swept to zero with in_tready low; counters clear at once.
// when the receiver stalls, the output register holds its result and the
// whole pipeline freezes, so in_tready drops while out_tvalid is high and
// out_tready low, and also during the clearing sweep.
module ipv4_port_filter_with_counters #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // frame_byte[7:0], port_number[23:8], counter_index[27:24]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  input  logic        in_tlast,   // end_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // drop_frame[0], counter_value[64:1]
  output logic        out_tuser   // result_kind[0]
);
  import ipf_pkg::*;

  // pipeline advance: stage 1 moves into the output register
  logic adv;
  logic busy;
  logic accept;
  op_t  in_op;

  // stage 1 registers (item whose bitmap row is being read)
  logic                 s1_vld_r;
  op_t                  s1_op_r;
  logic                 s1_last_r;
  cls_t                 s1_cls_r;
  logic [CNT_IDX_W-1:0] s1_idx_r;

  // output register
  logic        out_vld_r;
  logic        out_kind_r;
  logic        out_drop_r;
  logic [63:0] out_val_r;

  logic [PORT_W-1:0]        parse_port;
  cls_t                     cls;
  logic [PORT_W-1:0]        lookup_port;
  logic                     port_bit;
  logic                     upd_en;
  logic                     verdict;
  logic                     s1_frame_end;
  cnt_bump_t                bump;
  logic [COUNTER_WIDTH-1:0] cnt_val;

  assign in_op     = op_t'(in_tuser);
  assign adv       = !busy && (!out_vld_r || out_tready);
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  ipf_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (accept && in_op == OP_BYTE),
    .frame_byte (in_tdata[7:0]),
    .last       (in_tlast),
    .dest_port  (parse_port),
    .cls        (cls)
  );

  // frame bytes look up the captured port, commands the given one
  assign lookup_port = (in_op == OP_BYTE) ? parse_port : in_tdata[23:8];

  // write back only for block/unblock leaving stage 1
  assign upd_en = adv && s1_vld_r && (s1_op_r == OP_BLOCK || s1_op_r == OP_UNBLOCK);

  ipf_bitmap u_bitmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .req_en   (adv),
    .req_port (lookup_port),
    .upd_en   (upd_en),
    .upd_set  (s1_op_r == OP_BLOCK),
    .port_bit (port_bit)
  );

  assign s1_frame_end = s1_vld_r && s1_op_r == OP_BYTE && s1_last_r;
  assign verdict      = s1_cls_r.check_port && port_bit;

  // counters bump as the verdict leaves stage 1, so a later read sees them
  always_comb begin
    bump = '0;
    if (adv && s1_frame_end) begin
      bump[CNT_TOTAL]   = s1_cls_r.total;
      bump[CNT_IPV4]    = s1_cls_r.ipv4;
      bump[CNT_IPV6]    = s1_cls_r.ipv6;
      bump[CNT_TCP]     = s1_cls_r.tcp;
      bump[CNT_UDP]     = s1_cls_r.udp;
      bump[CNT_ICMP]    = s1_cls_r.icmp;
      bump[CNT_OTHER]   = s1_cls_r.other;
      bump[CNT_DROPPED] = verdict;
      bump[CNT_PASSED]  = !verdict;
    end
  end

  ipf_counters #(
    .CW (COUNTER_WIDTH)
  ) u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .bump   (bump),
    .rd_idx (s1_idx_r),
    .rd_val (cnt_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_tvalid;
      out_vld_r <= s1_frame_end || (s1_vld_r && s1_op_r == OP_READ);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_op;
      s1_last_r  <= in_tlast;
      s1_cls_r   <= cls;
      s1_idx_r   <= in_tdata[27:24];
      out_kind_r <= (s1_op_r == OP_READ) ? KIND_COUNT : KIND_VERDICT;
      out_drop_r <= (s1_op_r == OP_READ) ? 1'b0 : verdict;
      out_val_r  <= (s1_op_r == OP_READ) ? 64'(cnt_val) : 64'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_val_r, out_drop_r};

endmodule
